### rtl/qpd_pkg.sv
// Shared types, character codes and hex helpers for the quoted-printable decoder.
package qpd_pkg;

   localparam logic [7:0] CHAR_EQ = 8'h3D;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Decoder phase; codes above PH_EQHEX never arise and act as idle
   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_EQ    = 3'd1,
      PH_EQCR  = 3'd2,
      PH_EQLF  = 3'd3,
      PH_EQHEX = 3'd4
   } phase_type;

   // Bytes caused by one input transfer, in output order from data[0]
   typedef struct packed {
      logic [1:0]      count;
      logic [2:0][7:0] data;
   } packet_type;

   function automatic logic is_hex(input logic [7:0] c);
      return ((c >= 8'h30) && (c <= 8'h39)) ||
             ((c >= 8'h41) && (c <= 8'h46)) ||
             ((c >= 8'h61) && (c <= 8'h66));
   endfunction

   function automatic logic [3:0] digit_nibble(input logic [7:0] c);
      logic [7:0] v;
      if (c <= 8'h39) begin
         v = c - 8'h30;
      end else if (c <= 8'h46) begin
         v = c - 8'h37;
      end else begin
         v = c - 8'h57;
      end
      return v[3:0];
   endfunction

endpackage

### rtl/qpd_front.sv
// Front end: classifies each input byte, tracks escape phase and builds output packets.
module qpd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                fire,
   input  logic [7:0]          in_byte,
   input  logic                in_last,
   output logic                push,
   output qpd_pkg::packet_type packet
);

   qpd_pkg::phase_type phase_ff, phase_in;
   logic [7:0]         held_ff, held_in;

   // Append one byte to a packet; a packet never holds more than three
   function automatic qpd_pkg::packet_type add_byte(input qpd_pkg::packet_type p,
                                                     input logic [7:0] x);
      qpd_pkg::packet_type r;
      r = p;
      if (p.count != 2'd3) begin
         r.data[p.count] = x;
         r.count         = p.count + 2'd1;
      end
      return r;
   endfunction

   // Hold phase and the held digit
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= qpd_pkg::PH_IDLE;
         held_ff  <= 8'h00;
      end else if (fire) begin
         phase_ff <= phase_in;
         held_ff  <= held_in;
      end
   end

   // Work out the next phase and the bytes this transfer releases
   always_comb begin
      qpd_pkg::packet_type p;
      logic                restart;
      p        = '0;
      restart  = 1'b0;
      phase_in = phase_ff;
      held_in  = held_ff;

      unique case (phase_ff)
         qpd_pkg::PH_EQ: begin
            if (in_byte == qpd_pkg::CHAR_CR) begin
               phase_in = qpd_pkg::PH_EQCR;
            end else if (in_byte == qpd_pkg::CHAR_LF) begin
               phase_in = qpd_pkg::PH_EQLF;
            end else if (qpd_pkg::is_hex(in_byte)) begin
               held_in  = in_byte;
               phase_in = qpd_pkg::PH_EQHEX;
            end else begin
               p       = add_byte(p, qpd_pkg::CHAR_EQ);
               restart = 1'b1;
            end
         end
         qpd_pkg::PH_EQCR: begin
            if (in_byte == qpd_pkg::CHAR_LF) begin
               phase_in = qpd_pkg::PH_IDLE;
            end else begin
               p       = add_byte(p, qpd_pkg::CHAR_EQ);
               p       = add_byte(p, qpd_pkg::CHAR_CR);
               restart = 1'b1;
            end
         end
         qpd_pkg::PH_EQHEX: begin
            if (qpd_pkg::is_hex(held_ff) && qpd_pkg::is_hex(in_byte)) begin
               p        = add_byte(p, {qpd_pkg::digit_nibble(held_ff),
                                       qpd_pkg::digit_nibble(in_byte)});
               phase_in = qpd_pkg::PH_IDLE;
            end else begin
               p       = add_byte(p, qpd_pkg::CHAR_EQ);
               p       = add_byte(p, held_ff);
               restart = 1'b1;
            end
         end
         default: begin
            restart = 1'b1;
         end
      endcase

      // Handle the current byte again as if idle
      if (restart) begin
         if (in_byte == qpd_pkg::CHAR_EQ) begin
            phase_in = qpd_pkg::PH_EQ;
         end else begin
            phase_in = qpd_pkg::PH_IDLE;
            p        = add_byte(p, in_byte);
         end
      end

      // Flush whatever is pending at end of text
      if (in_last) begin
         unique case (phase_in)
            qpd_pkg::PH_EQ: begin
               p = add_byte(p, qpd_pkg::CHAR_EQ);
            end
            qpd_pkg::PH_EQCR: begin
               p = add_byte(p, qpd_pkg::CHAR_EQ);
               p = add_byte(p, qpd_pkg::CHAR_CR);
            end
            qpd_pkg::PH_EQLF: begin
               p = add_byte(p, qpd_pkg::CHAR_EQ);
               p = add_byte(p, qpd_pkg::CHAR_LF);
            end
            qpd_pkg::PH_EQHEX: begin
               p = add_byte(p, qpd_pkg::CHAR_EQ);
               p = add_byte(p, held_in);
            end
            default: begin
            end
         endcase
         phase_in = qpd_pkg::PH_IDLE;
      end

      packet = p;
      push   = fire && (p.count != 2'd0);
   end

endmodule

### rtl/qpd_queue.sv
// Short packet queue between the front end and the output sequencer.
module qpd_queue #(
   parameter int DEPTH = qpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  qpd_pkg::packet_type push_data,
   input  logic                pop,
   output logic                full,
   output logic                head_valid,
   output qpd_pkg::packet_type head
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   qpd_pkg::packet_type entries_ff [DEPTH];
   logic [PW-1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0]       count_ff;

   // Store pushed packets
   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entries_ff[rd_ptr_ff];

endmodule

### rtl/qpd_back.sv
// Back end: walks the head packet byte by byte into the output register.
module qpd_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                head_valid,
   input  qpd_pkg::packet_type head,
   output logic                pop,
   input  logic                rsp_tready,
   output logic                rsp_tvalid,
   output logic [7:0]          rsp_tdata,
   output logic                rsp_tlast
);

   logic       valid_ff, valid_in;
   logic [1:0] idx_ff, idx_in;
   logic [7:0] data_ff;
   logic       last_ff;
   logic       load, final_byte;

   assign load       = head_valid && (!valid_ff || rsp_tready);
   assign final_byte = (idx_ff == (head.count - 2'd1));
   assign pop        = load && final_byte;

   // Pick next byte index and output valid
   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = final_byte ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   // Load the output payload
   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= head.data[idx_ff];
         last_ff <= final_byte;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

### rtl/quoted_printable_decoder_unit.sv
// Streaming quoted-printable decoder, top level.
// One encoded byte is taken per cycle while the packet queue has room; each transfer
// yields zero to three decoded bytes, and the output register sends one byte per cycle
// while rsp_tready is high, so throughput is one input byte per cycle except where a byte
// expands to two or three outputs, when the output side sets the rate and the queue of
// QUEUE_DEPTH packets absorbs the burst. Each decoded byte passes the queue, then the output register.
// rsp_tlast marks the last decoded byte caused by a given input byte; bytes that cause
// no output produce no transfer.
module quoted_printable_decoder_unit #(
   parameter int QUEUE_DEPTH = qpd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tlast,   // in_last
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tlast    // run_last
);

   logic                fire, push, pop, full, head_valid;
   qpd_pkg::packet_type packet, head;

   assign req_tready = !full;
   assign fire       = req_tvalid && req_tready;

   qpd_front u_front (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .in_byte (req_tdata),
      .in_last (req_tlast),
      .push    (push),
      .packet  (packet)
   );

   qpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (packet),
      .pop        (pop),
      .full       (full),
      .head_valid (head_valid),
      .head       (head)
   );

   qpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the streaming quoted-printable decoder unit.
module tb_top;

   localparam int CLK_HALF       = 4;
   localparam int RESET_CYCLES   = 7;
   localparam int DIR_ROWS       = 27;
   localparam int PHASE_ITEMS    = 128;
   localparam int HOLD_AT_RESULT = 40;
   localparam int HOLD_CYCLES    = 160;
   localparam int DRAIN_CYCLES   = 12;
   localparam int LIMIT_CYCLES   = 200_000;

   // One encoded byte to send; typed rows carry their own expected bytes
   typedef struct {
      logic [7:0] data;
      logic       last;
      bit         typed;
      int         n;
      logic [7:0] b [3];
   } text_byte_type;

   // One decoded byte as it should leave the block
   typedef struct {
      logic [7:0] data;
      logic       last;
   } decoded_byte_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;  // [7:0] in_byte
   logic       req_tlast  = 1'b0;   // in_last
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic       rsp_tlast;           // run_last

   // Decoder mirror state and queues
   qpd_pkg::phase_type dec_phase = qpd_pkg::PH_IDLE;
   logic [7:0]         dec_held  = 8'h00;
   logic [7:0]         step_bytes [$];
   decoded_byte_type   decoded_q [$];
   text_byte_type      offered_q [$];
   text_byte_type      text_q [$];

   int fail_count  = 0;
   int in_count    = 0;
   int out_count   = 0;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   int hold_left   = 0;
   bit hold_done   = 1'b0;
   int rx_taken    = 0;

   quoted_printable_decoder_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock, 8 ns period
   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // Value of a hex digit, -1 for any other byte
   function automatic int hex_nibble(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      return -1;
   endfunction

   // At most three bytes can come from one input byte
   function automatic void decode_emit(input logic [7:0] b);
      if (step_bytes.size() < 3) step_bytes.insert(step_bytes.size(), b);
   endfunction

   function automatic void decode_from_idle(input logic [7:0] b);
      if (b == qpd_pkg::CHAR_EQ) begin
         dec_phase = qpd_pkg::PH_EQ;
      end else begin
         dec_phase = qpd_pkg::PH_IDLE;
         decode_emit(b);
      end
   endfunction

   // Advance the decoder mirror by one byte
   function automatic void decode_take(input logic [7:0] b);
      logic [3:0] hi;
      logic [3:0] lo;
      case (dec_phase)
         qpd_pkg::PH_EQ: begin
            if (b == qpd_pkg::CHAR_CR) begin
               dec_phase = qpd_pkg::PH_EQCR;
            end else if (b == qpd_pkg::CHAR_LF) begin
               dec_phase = qpd_pkg::PH_EQLF;
            end else if (hex_nibble(b) >= 0) begin
               dec_held  = b;
               dec_phase = qpd_pkg::PH_EQHEX;
            end else begin
               decode_emit(qpd_pkg::CHAR_EQ);
               decode_from_idle(b);
            end
         end
         qpd_pkg::PH_EQCR: begin
            if (b == qpd_pkg::CHAR_LF) begin
               dec_phase = qpd_pkg::PH_IDLE;
            end else begin
               decode_emit(qpd_pkg::CHAR_EQ);
               decode_emit(qpd_pkg::CHAR_CR);
               decode_from_idle(b);
            end
         end
         qpd_pkg::PH_EQHEX: begin
            if (hex_nibble(b) >= 0) begin
               hi = 4'(hex_nibble(dec_held));
               lo = 4'(hex_nibble(b));
               decode_emit({hi, lo});
               dec_phase = qpd_pkg::PH_IDLE;
            end else begin
               decode_emit(qpd_pkg::CHAR_EQ);
               decode_emit(dec_held);
               decode_from_idle(b);
            end
         end
         default: begin
            decode_from_idle(b);
         end
      endcase
   endfunction

   // End of text: release whatever is still held back, literally
   function automatic void decode_flush();
      case (dec_phase)
         qpd_pkg::PH_EQ: begin
            decode_emit(qpd_pkg::CHAR_EQ);
         end
         qpd_pkg::PH_EQCR: begin
            decode_emit(qpd_pkg::CHAR_EQ);
            decode_emit(qpd_pkg::CHAR_CR);
         end
         qpd_pkg::PH_EQLF: begin
            decode_emit(qpd_pkg::CHAR_EQ);
            decode_emit(qpd_pkg::CHAR_LF);
         end
         qpd_pkg::PH_EQHEX: begin
            decode_emit(qpd_pkg::CHAR_EQ);
            decode_emit(dec_held);
         end
         default: begin
         end
      endcase
      dec_phase = qpd_pkg::PH_IDLE;
   endfunction

   // Work out the decoded bytes that one accepted input byte causes
   function automatic void decode_byte(input logic [7:0] b, input logic last);
      step_bytes.delete();
      decode_take(b);
      if (last) decode_flush();
   endfunction

   // Observe both channels: queue expectations on input, check on output
   always @(posedge clock) begin
      text_byte_type    row;
      decoded_byte_type want;
      if (!reset && req_tvalid && req_tready) begin
         row = offered_q.pop_front();
         in_count++;
         decode_byte(row.data, row.last);
         if (row.typed) begin
            for (int i = 0; i < row.n; i++) begin
               want.data = row.b[i];
               want.last = (i == row.n - 1);
               decoded_q.insert(decoded_q.size(), want);
            end
         end else begin
            for (int i = 0; i < step_bytes.size(); i++) begin
               want.data = step_bytes[i];
               want.last = (i == step_bytes.size() - 1);
               decoded_q.insert(decoded_q.size(), want);
            end
         end
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         out_count++;
         if (decoded_q.size() == 0) begin
            $error("unexpected output transfer: out_byte %h run_last %b",
                   rsp_tdata, rsp_tlast);
            fail_count++;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_tdata !== want.data) begin
               $error("out_byte mismatch: expected %h, actual %h", want.data, rsp_tdata);
               fail_count++;
            end
            if (rsp_tlast !== want.last) begin
               $error("run_last mismatch: expected %b, actual %b", want.last, rsp_tlast);
               fail_count++;
            end
         end
      end
   end

   // Drive output ready; hold off once for a long stretch to back the block up
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready) rx_taken++;
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (!hold_done && rx_taken >= HOLD_AT_RESULT) begin
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   // Offer one byte, with random idle cycles ahead of it
   task automatic send_byte(input text_byte_type row);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= row.data;
      req_tlast  <= row.last;
      offered_q.insert(offered_q.size(), row);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop sending and wait until every decoded byte has come out
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] rand_hex_char();
      int v;
      v = $urandom_range(15);
      if (v < 10) return 8'("0" + v);
      if ($urandom_range(1)) return 8'("A" + v - 10);
      return 8'("a" + v - 10);
   endfunction

   function automatic void push_text(input logic [7:0] b);
      text_byte_type row;
      row.data  = b;
      row.last  = ($urandom_range(39) == 0);
      row.typed = 1'b0;
      row.n     = 0;
      row.b     = '{8'h00, 8'h00, 8'h00};
      text_q.insert(text_q.size(), row);
   endfunction

   // Build encoded text: literal bytes, well-formed escapes and soft breaks, some broken
   function automatic void build_text(input int count);
      int         kind;
      logic [7:0] b;
      while (text_q.size() < count) begin
         kind = $urandom_range(99);
         if (kind < 30) begin
            b = 8'($urandom_range(255));
            push_text((b == qpd_pkg::CHAR_EQ) ? 8'h41 : b);
         end else if (kind < 60) begin
            push_text(qpd_pkg::CHAR_EQ);
            push_text(rand_hex_char());
            push_text(rand_hex_char());
         end else if (kind < 70) begin
            push_text(qpd_pkg::CHAR_EQ);
            push_text(qpd_pkg::CHAR_CR);
            push_text(qpd_pkg::CHAR_LF);
         end else if (kind < 78) begin
            push_text(qpd_pkg::CHAR_EQ);
            push_text(qpd_pkg::CHAR_LF);
            push_text(8'($urandom_range(255)));
         end else if (kind < 84) begin
            // broken escape: the byte after the equals is no digit, CR or LF
            do b = 8'($urandom_range(255));
            while (hex_nibble(b) >= 0 || b == qpd_pkg::CHAR_CR || b == qpd_pkg::CHAR_LF);
            push_text(qpd_pkg::CHAR_EQ);
            push_text(b);
         end else if (kind < 89) begin
            do b = 8'($urandom_range(255)); while (b == qpd_pkg::CHAR_LF);
            push_text(qpd_pkg::CHAR_EQ);
            push_text(qpd_pkg::CHAR_CR);
            push_text(b);
         end else if (kind < 94) begin
            // lone first digit
            do b = 8'($urandom_range(255)); while (hex_nibble(b) >= 0);
            push_text(qpd_pkg::CHAR_EQ);
            push_text(rand_hex_char());
            push_text(b);
         end else begin
            push_text(8'($urandom_range(255)));
         end
         if ($urandom_range(11) == 0) text_q[text_q.size() - 1].last = 1'b1;
      end
   endfunction

   // Stimulus: directed table, then three random phases with different idling
   initial begin
      text_byte_type dir_tab [DIR_ROWS];
      dir_tab = '{
         '{"A",              1'b0, 1'b1, 1, '{"A",   8'h00, 8'h00}},
         '{8'h00,            1'b0, 1'b1, 1, '{8'h00, 8'h00, 8'h00}},
         '{8'hFF,            1'b0, 1'b1, 1, '{8'hFF, 8'h00, 8'h00}},
         '{qpd_pkg::CHAR_EQ, 1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
         '{"4",              1'b0, 1'b1, 0, '{8'h00, 8'h00, 8'h00}},
         '{"1",              1'b0, 1'b1, 1, '{8'h41, 8'h00, 8'h00}},
         // lower then upper case digits
         '{qpd_pkg::CHAR_EQ, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{"f",              1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{"F",              1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         // soft line break
         '{qpd_pkg::CHAR_EQ, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{qpd_pkg::CHAR_CR, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{qpd_pkg::CHAR_LF, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         // broken escape
         '{qpd_pkg::CHAR_EQ, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{"Z",              1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         // broken soft break
         '{qpd_pkg::CHAR_EQ, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{qpd_pkg::CHAR_CR, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{"x",              1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         // lone digit, the next equals starts a new escape, then equals LF
         '{qpd_pkg::CHAR_EQ, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{"a",              1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{qpd_pkg::CHAR_EQ, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{qpd_pkg::CHAR_LF, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{"q",              1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         // end of text with a broken soft break and a pending equals: three bytes
         '{qpd_pkg::CHAR_EQ, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{qpd_pkg::CHAR_CR, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{qpd_pkg::CHAR_EQ, 1'b1, 1'b1, 3,
           '{qpd_pkg::CHAR_EQ, qpd_pkg::CHAR_CR, qpd_pkg::CHAR_EQ}},
         // end of text right after equals LF
         '{qpd_pkg::CHAR_EQ, 1'b0, 1'b0, 0, '{8'h00, 8'h00, 8'h00}},
         '{qpd_pkg::CHAR_LF, 1'b1, 1'b1, 2,
           '{qpd_pkg::CHAR_EQ, qpd_pkg::CHAR_LF, 8'h00}}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_tab[i]) send_byte(dir_tab[i]);
      wait_drained();

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: begin
               tx_idle_pct = 17;
               rx_idle_pct = 57;
            end
            1: begin
               tx_idle_pct = 57;
               rx_idle_pct = 17;
            end
            default: begin
               tx_idle_pct = 0;
               rx_idle_pct = 0;
            end
         endcase
         text_q.delete();
         build_text(PHASE_ITEMS);
         while (text_q.size() > 0) send_byte(text_q.pop_front());
         wait_drained();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d encoded bytes and checked %0d decoded bytes", in_count, out_count);
      $display("Phases: directed cases, skewed idling both ways, full rate, long output stall");
      if (fail_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(LIMIT_CYCLES * CLK_HALF * 2);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
